[sv/tpdf_pkg.sv]
package tpdf_pkg;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_SAMPLE = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic [16:0] FRAC_ONE = 17'd65536;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_CLEAR,
      CMD_INC,
      CMD_WR_PDF,
      CMD_FULL,
      CMD_SHIFT_INIT,
      CMD_DEC,
      CMD_SHIFT_WR,
      CMD_PUT_NEW,
      CMD_RB_INIT,
      CMD_RB_FIRST,
      CMD_RB_MUL,
      CMD_RB_ACC,
      CMD_EMPTY,
      CMD_SET_LAST,
      CMD_TAKE_X,
      CMD_MUL_LO,
      CMD_MUL_HI,
      CMD_TARGET,
      CMD_SCAN_NEXT,
      CMD_DIV_INIT,
      CMD_DIV_STEP,
      CMD_DIV_END,
      CMD_RESPOND
   } cmd_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_INS_RD,
      S_INS_CMP,
      S_SHF_CHK,
      S_SHF_RD,
      S_SHF_WR,
      S_RB_INIT,
      S_RB_RD0,
      S_RB_FIRST,
      S_RB_CHK,
      S_RB_RD,
      S_RB_MUL,
      S_RB_ACC,
      S_SMP_RD,
      S_SMP_T,
      S_SMP_H,
      S_SMP_TG,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_DIV,
      S_DIV_END,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0] op;
      logic       cnt_zero;
      logic       cnt_one;
      logic       cnt_full;
      logic       idx_lt_cnt;
      logic       idx_zero;
      logic       idx_last;
      logic       idx_eq_pos;
      logic       x_less;
      logic       x_equal;
      logic       tgt_le;
      logic       div_last;
      logic       out_busy;
   } dp_status_type;

endpackage

[sv/tpdf_ctrl.sv]
module tpdf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tpdf_pkg::dp_status_type st,
   output tpdf_pkg::cmd_type      cmd
);
   import tpdf_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = CMD_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (st.op)
               OP_CLEAR: begin
                  cmd      = CMD_CLEAR;
                  state_in = S_DONE;
               end
               OP_INSERT: state_in = S_INS_RD;
               OP_SAMPLE: begin
                  if (st.cnt_zero) begin
                     cmd      = CMD_EMPTY;
                     state_in = S_DONE;
                  end else begin
                     cmd      = CMD_SET_LAST;
                     state_in = S_SMP_RD;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_INS_RD: state_in = S_INS_CMP;
         S_INS_CMP: begin
            if (st.idx_lt_cnt && st.x_less) begin
               cmd      = CMD_INC;
               state_in = S_INS_RD;
            end else if (st.idx_lt_cnt && st.x_equal) begin
               cmd      = CMD_WR_PDF;
               state_in = S_RB_INIT;
            end else if (st.cnt_full) begin
               cmd      = CMD_FULL;
               state_in = S_DONE;
            end else begin
               cmd      = CMD_SHIFT_INIT;
               state_in = S_SHF_CHK;
            end
         end
         S_SHF_CHK: begin
            if (st.idx_eq_pos) begin
               cmd      = CMD_PUT_NEW;
               state_in = S_RB_INIT;
            end else begin
               cmd      = CMD_DEC;
               state_in = S_SHF_RD;
            end
         end
         S_SHF_RD: state_in = S_SHF_WR;
         S_SHF_WR: begin
            cmd      = CMD_SHIFT_WR;
            state_in = S_SHF_CHK;
         end
         S_RB_INIT: begin
            cmd      = CMD_RB_INIT;
            state_in = S_RB_RD0;
         end
         S_RB_RD0: state_in = S_RB_FIRST;
         S_RB_FIRST: begin
            cmd      = CMD_RB_FIRST;
            state_in = S_RB_CHK;
         end
         S_RB_CHK: state_in = st.idx_lt_cnt ? S_RB_RD : S_DONE;
         S_RB_RD: state_in = S_RB_MUL;
         S_RB_MUL: begin
            cmd      = CMD_RB_MUL;
            state_in = S_RB_ACC;
         end
         S_RB_ACC: begin
            cmd      = CMD_RB_ACC;
            state_in = S_RB_CHK;
         end
         S_SMP_RD: state_in = S_SMP_T;
         S_SMP_T: begin
            if (st.cnt_one) begin
               cmd      = CMD_TAKE_X;
               state_in = S_DONE;
            end else begin
               cmd      = CMD_MUL_LO;
               state_in = S_SMP_H;
            end
         end
         S_SMP_H: begin
            cmd      = CMD_MUL_HI;
            state_in = S_SMP_TG;
         end
         S_SMP_TG: begin
            cmd      = CMD_TARGET;
            state_in = S_SCAN_RD;
         end
         S_SCAN_RD: state_in = S_SCAN_CMP;
         S_SCAN_CMP: begin
            if (st.tgt_le) begin
               if (st.idx_zero) begin
                  cmd      = CMD_TAKE_X;
                  state_in = S_DONE;
               end else begin
                  cmd      = CMD_DIV_INIT;
                  state_in = S_DIV;
               end
            end else if (st.idx_last) begin
               cmd      = CMD_TAKE_X;
               state_in = S_DONE;
            end else begin
               cmd      = CMD_SCAN_NEXT;
               state_in = S_SCAN_RD;
            end
         end
         S_DIV: begin
            cmd = CMD_DIV_STEP;
            if (st.div_last) state_in = S_DIV_END;
         end
         S_DIV_END: begin
            cmd      = CMD_DIV_END;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!st.out_busy) begin
               cmd      = CMD_RESPOND;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // a shift pass only starts from the scan, so it never runs into an empty slot search
   a_shift_from_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHF_CHK) |-> ($past(state_ff) == S_INS_CMP || $past(state_ff) == S_SHF_WR))
      else $error("shift pass entered from wrong state");
   a_div_from_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && $past(state_ff) != S_DIV) |-> $past(state_ff) == S_SCAN_CMP)
      else $error("divider started outside the scan");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_LOAD) |=> state_ff == S_DISPATCH)
      else $error("accepted transfer not dispatched");

endmodule

[sv/tpdf_datapath.sv]
module tpdf_datapath #(
   parameter int MAX_POINTS = 256,
   parameter int AW = 8,
   parameter int CW = 9
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tpdf_pkg::cmd_type       cmd,
   output tpdf_pkg::dp_status_type st,
   input  logic [1:0]              req_operation,
   input  logic signed [31:0]      req_point_x,
   input  logic [31:0]             req_point_pdf,
   input  logic [16:0]             req_rand_fraction,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [31:0]      rsp_sample_x,
   output logic [1:0]              rsp_status,
   output logic [CW-1:0]           rsp_point_count
);
   import tpdf_pkg::*;

   logic [31:0] x_mem_ff [MAX_POINTS];
   logic [31:0] p_mem_ff [MAX_POINTS];
   logic [63:0] c_mem_ff [MAX_POINTS];

   logic [31:0] xr_ff, pr_ff;
   logic [63:0] cr_ff;

   logic [1:0]    op_ff;
   logic [31:0]   px_ff, pin_ff;
   logic [16:0]   frac_ff;
   logic [CW-1:0] count_ff, idx_ff, pos_ff;
   logic [31:0]   prev_x_ff, prev_p_ff;
   logic [63:0]   prev_c_ff, area_ff, target_ff;
   logic [31:0]   tot_hi_ff;
   logic [48:0]   plo_ff, phi_ff;
   logic [63:0]   r_ff, num_ff, den_ff;
   logic [31:0]   q_ff, mul_ff, x0_ff;
   logic [4:0]    div_cnt_ff;
   logic [31:0]   sx_ff;
   logic [1:0]    status_ff;
   logic          out_valid_ff;
   logic [31:0]   out_sx_ff;
   logic [1:0]    out_status_ff;
   logic [CW-1:0] out_count_ff;

   logic          x_we, p_we, c_we;
   logic [AW-1:0] wa, ra;
   logic [31:0]   x_wd, p_wd;
   logic [63:0]   c_wd;

   logic [32:0]   pair_sum;
   logic [31:0]   dx;
   logic [63:0]   area_calc;
   logic [64:0]   acc_sum;
   logic [63:0]   acc_sat;
   logic [80:0]   full_prod;
   logic [63:0]   r1, r2, dn;
   logic [31:0]   q1, q2;
   logic          c1, c2;

   assign ra = idx_ff[AW-1:0];

   always_comb begin
      x_we = 1'b0;
      p_we = 1'b0;
      c_we = 1'b0;
      wa   = idx_ff[AW-1:0];
      x_wd = px_ff;
      p_wd = pin_ff;
      c_wd = acc_sat;
      case (cmd)
         CMD_WR_PDF: p_we = 1'b1;
         CMD_SHIFT_WR: begin
            x_we = 1'b1;
            p_we = 1'b1;
            wa   = AW'(idx_ff + CW'(1));
            x_wd = xr_ff;
            p_wd = pr_ff;
         end
         CMD_PUT_NEW: begin
            x_we = 1'b1;
            p_we = 1'b1;
         end
         CMD_RB_FIRST: begin
            c_we = 1'b1;
            c_wd = 64'd0;
         end
         CMD_RB_ACC: c_we = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (x_we) x_mem_ff[wa] <= x_wd;
      if (p_we) p_mem_ff[wa] <= p_wd;
      if (c_we) c_mem_ff[wa] <= c_wd;
      xr_ff <= x_mem_ff[ra];
      pr_ff <= p_mem_ff[ra];
      cr_ff <= c_mem_ff[ra];
   end

   // trapezoid slice and saturating accumulate
   assign pair_sum  = {1'b0, prev_p_ff} + {1'b0, pr_ff};
   assign dx        = xr_ff - prev_x_ff;
   assign area_calc = pair_sum[32:1] * dx + (pair_sum[0] ? {33'd0, dx[31:1]} : 64'd0);
   assign acc_sum   = {1'b0, prev_c_ff} + {1'b0, area_ff};
   assign acc_sat   = acc_sum[64] ? {64{1'b1}} : acc_sum[63:0];

   assign full_prod = {phi_ff, 32'd0} + {32'd0, plo_ff};

   // one quotient bit of floor(mul * num / den) per cycle
   always_comb begin
      c1 = (r_ff >= den_ff - r_ff);
      r1 = c1 ? (r_ff - (den_ff - r_ff)) : {r_ff[62:0], 1'b0};
      q1 = {q_ff[30:0], c1};
      dn = den_ff - num_ff;
      c2 = mul_ff[31] && (r1 >= dn);
      r2 = r1;
      if (mul_ff[31]) r2 = c2 ? (r1 - dn) : (r1 + num_ff);
      q2 = q1 + {31'd0, c2};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd == CMD_RESPOND)            out_valid_ff <= 1'b1;
         else if (out_valid_ff && rsp_ready) out_valid_ff <= 1'b0;
         case (cmd)
            CMD_CLEAR:   count_ff <= '0;
            CMD_PUT_NEW: count_ff <= count_ff + CW'(1);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd)
         CMD_LOAD: begin
            op_ff     <= req_operation;
            px_ff     <= req_point_x;
            pin_ff    <= req_point_pdf;
            frac_ff   <= (req_rand_fraction > FRAC_ONE) ? FRAC_ONE : req_rand_fraction;
            idx_ff    <= '0;
            sx_ff     <= 32'd0;
            status_ff <= STATUS_OK;
         end
         CMD_INC:        idx_ff <= idx_ff + CW'(1);
         CMD_FULL:       status_ff <= STATUS_FULL;
         CMD_SHIFT_INIT: begin
            pos_ff <= idx_ff;
            idx_ff <= count_ff;
         end
         CMD_DEC:        idx_ff <= idx_ff - CW'(1);
         CMD_RB_INIT:    idx_ff <= '0;
         CMD_RB_FIRST: begin
            prev_x_ff <= xr_ff;
            prev_p_ff <= pr_ff;
            prev_c_ff <= 64'd0;
            idx_ff    <= CW'(1);
         end
         CMD_RB_MUL: begin
            area_ff   <= area_calc;
            prev_x_ff <= xr_ff;
            prev_p_ff <= pr_ff;
         end
         CMD_RB_ACC: begin
            prev_c_ff <= acc_sat;
            idx_ff    <= idx_ff + CW'(1);
         end
         CMD_EMPTY:    status_ff <= STATUS_EMPTY;
         CMD_SET_LAST: idx_ff <= count_ff - CW'(1);
         CMD_TAKE_X:   sx_ff <= xr_ff;
         CMD_MUL_LO: begin
            plo_ff    <= cr_ff[31:0] * frac_ff;
            tot_hi_ff <= cr_ff[63:32];
         end
         CMD_MUL_HI:   phi_ff <= tot_hi_ff * frac_ff;
         CMD_TARGET: begin
            target_ff <= full_prod[79:16];
            idx_ff    <= '0;
         end
         CMD_SCAN_NEXT: begin
            prev_c_ff <= cr_ff;
            prev_x_ff <= xr_ff;
            idx_ff    <= idx_ff + CW'(1);
         end
         CMD_DIV_INIT: begin
            den_ff     <= cr_ff - prev_c_ff;
            num_ff     <= target_ff - prev_c_ff;
            mul_ff     <= xr_ff - prev_x_ff;
            x0_ff      <= prev_x_ff;
            r_ff       <= 64'd0;
            q_ff       <= 32'd0;
            div_cnt_ff <= 5'd0;
         end
         CMD_DIV_STEP: begin
            r_ff       <= r2;
            q_ff       <= q2;
            mul_ff     <= {mul_ff[30:0], 1'b0};
            div_cnt_ff <= div_cnt_ff + 5'd1;
         end
         CMD_DIV_END:  sx_ff <= x0_ff + q_ff;
         CMD_RESPOND: begin
            out_sx_ff     <= sx_ff;
            out_status_ff <= status_ff;
            out_count_ff  <= count_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      st.op         = op_ff;
      st.cnt_zero   = (count_ff == '0);
      st.cnt_one    = (count_ff == CW'(1));
      st.cnt_full   = (count_ff == CW'(MAX_POINTS));
      st.idx_lt_cnt = (idx_ff < count_ff);
      st.idx_zero   = (idx_ff == '0);
      st.idx_last   = (idx_ff == count_ff - CW'(1));
      st.idx_eq_pos = (idx_ff == pos_ff);
      st.x_less     = ($signed(xr_ff) < $signed(px_ff));
      st.x_equal    = (xr_ff == px_ff);
      st.tgt_le     = (target_ff <= cr_ff);
      st.div_last   = (div_cnt_ff == 5'd31);
      st.out_busy   = out_valid_ff && !rsp_ready;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_sample_x    = out_sx_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_point_count = out_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS))
      else $error("point count above capacity");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_CLEAR) |=> count_ff == '0)
      else $error("clear did not empty the table");
   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_SHIFT_WR) |-> (idx_ff < count_ff && idx_ff >= pos_ff))
      else $error("shift outside the held entries");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_RESPOND) |-> !(out_valid_ff && !rsp_ready))
      else $error("result overwritten before transfer");

endmodule

[sv/tabulated_pdf_inverse_sampler_top.sv]
// tabulated density sampler: holds up to MAX_POINTS (x, pdf) points sorted by x
// req channel (valid/ready): operation clear, insert (point_x, point_pdf) or
// sample (rand_fraction); one rsp transfer per req with sample_x, status, point_count
// one item is worked at a time; req_ready is high only while the sequencer idles
// clear and unused codes go from dispatch straight to the result step
// insert: its run is set by the sorted-position scan, the shift pass and the
// running-integral rebuild, each moving one entry per step through the table
// memories, which have one read and one write port each
// sample: its run is set by the integral scan and the 32-step bit-serial
// interpolation divider
// results sit in an output register; a stalled receiver holds the finished result
// there, and the next item is taken but waits before its own result is written
// reset (synchronous) empties the table and drops any pending result; the table
// memories are not cleared and entries beyond the point count are never read
module tabulated_pdf_inverse_sampler_top #(
   parameter int MAX_POINTS = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_operation,
   input  logic signed [31:0]                   req_point_x,
   input  logic [31:0]                          req_point_pdf,
   input  logic [16:0]                          req_rand_fraction,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [31:0]                   rsp_sample_x,
   output logic [1:0]                           rsp_status,
   output logic [$clog2(MAX_POINTS+1)-1:0]      rsp_point_count
);
   import tpdf_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   cmd_type       cmd;
   dp_status_type st;

   tpdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   tpdf_datapath #(
      .MAX_POINTS (MAX_POINTS),
      .AW         (AW),
      .CW         (CW)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .st                (st),
      .req_operation     (req_operation),
      .req_point_x       (req_point_x),
      .req_point_pdf     (req_point_pdf),
      .req_rand_fraction (req_rand_fraction),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sample_x      (rsp_sample_x),
      .rsp_status        (rsp_status),
      .rsp_point_count   (rsp_point_count)
   );

endmodule
